@@ hdl/ced_pkg.sv @@
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, character codes and the escape letter map for the C escape
// sequence decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  // Parser modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_t;

  // Character codes
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_OCT_LO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_OCT_HI    = 8'h37;  // '7'
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_V         = 8'h76;
  localparam logic [7:0] CHAR_A         = 8'h61;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  // One queued job: one or two decoded characters from a single input byte.
  // The last flag belongs to the final character of the job.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;
  } job_t;

  // Map an escaped letter to its control code; anything else is itself.
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CHAR_N:  r = 8'd10;
      CHAR_T:  r = 8'd9;
      CHAR_B:  r = 8'd8;
      CHAR_R:  r = 8'd13;
      CHAR_F:  r = 8'd12;
      CHAR_V:  r = 8'd11;
      CHAR_A:  r = 8'd7;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ced_if.sv @@
// ----------------------------------------------------------------------------
// ced_if
// Valid/ready channels for source characters and decoded characters.
// ----------------------------------------------------------------------------
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ hdl/c_escape_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Unescapes a C string presented one character per transaction.
// ----------------------------------------------------------------------------
// The block accepts one source byte every cycle while its queue has room. Each
// byte yields zero, one or two decoded characters, and the output stage sends
// one character per cycle while out_ch.ready is high, so a byte that closes an
// octal run and also produces its own character gives it two characters. A
// queue of QueueDepth jobs sits between the parser and the output register;
// input ready drops only when that queue is full. An accepted byte reaches the
// output through the queue storage and then the output register. A zero byte
// ends the string with a zero character flagged last, and the parser is then ready for the next string.
module c_escape_sequence_decoder #(
  parameter int QueueDepth = 4
) (
  input logic             clk,
  input logic             rst,
  ced_in_if.sink          in_ch,
  ced_out_if.source       out_ch
);

  logic          push;
  ced_pkg::job_t push_job;
  logic          q_not_full;
  logic          q_not_empty;
  logic          q_pop;
  ced_pkg::job_t q_head;

  ced_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .push     (push),
    .job      (push_job),
    .q_ready  (q_not_full)
  );

  ced_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  ced_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_job     (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
  );

endmodule

@@ hdl/ced_front.sv @@
// ----------------------------------------------------------------------------
// ced_front
// Parser: takes one source byte per transaction, tracks escape and octal
// state, and turns each byte into a job of zero, one or two characters.
// ----------------------------------------------------------------------------
module ced_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  output logic          push,
  output ced_pkg::job_t job,
  input  logic          q_ready
);

  ced_pkg::mode_t mode, mode_next;
  logic [8:0]     oct_val, oct_val_next;
  logic [1:0]     oct_cnt, oct_cnt_next;
  logic           fire;
  logic           is_oct;
  logic           emit;

  assign in_ready = q_ready;
  assign fire     = in_valid && q_ready;
  assign is_oct   = (in_byte >= ced_pkg::CHAR_OCT_LO) && (in_byte <= ced_pkg::CHAR_OCT_HI);
  assign push     = fire && emit;

  // Hold parser state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ced_pkg::MODE_NORMAL;
      oct_val <= '0;
      oct_cnt <= '0;
    end else if (fire) begin
      mode    <= mode_next;
      oct_val <= oct_val_next;
      oct_cnt <= oct_cnt_next;
    end
  end

  // Classify the byte against the current mode
  always_comb begin
    mode_next    = ced_pkg::MODE_NORMAL;
    oct_val_next = '0;
    oct_cnt_next = '0;
    emit         = 1'b0;
    job          = '0;
    unique case (mode)
      ced_pkg::MODE_OCTAL: begin
        if (is_oct) begin
          oct_val_next = {oct_val[5:0], in_byte[2:0]};
          oct_cnt_next = oct_cnt + 2'd1;
          if (oct_cnt_next == ced_pkg::OCT_MAX_DIGITS) begin
            // Third digit closes the run
            emit         = 1'b1;
            job.byte0    = oct_val_next[7:0];
            oct_val_next = '0;
            oct_cnt_next = '0;
          end else begin
            mode_next = ced_pkg::MODE_OCTAL;
          end
        end else begin
          // Flush the run, then treat the byte as plain
          emit      = 1'b1;
          job.byte0 = oct_val[7:0];
          if (in_byte == ced_pkg::CHAR_NUL) begin
            job.two   = 1'b1;
            job.byte1 = ced_pkg::CHAR_NUL;
            job.last  = 1'b1;
          end else if (in_byte == ced_pkg::CHAR_BACKSLASH) begin
            mode_next = ced_pkg::MODE_ESCAPE;
          end else begin
            job.two   = 1'b1;
            job.byte1 = in_byte;
          end
        end
      end
      ced_pkg::MODE_ESCAPE: begin
        if (in_byte == ced_pkg::CHAR_NUL) begin
          // Drop a dangling backslash before the terminator
          emit      = 1'b1;
          job.byte0 = ced_pkg::CHAR_NUL;
          job.last  = 1'b1;
        end else if (is_oct) begin
          mode_next    = ced_pkg::MODE_OCTAL;
          oct_val_next = {6'd0, in_byte[2:0]};
          oct_cnt_next = 2'd1;
        end else begin
          emit      = 1'b1;
          job.byte0 = ced_pkg::esc_map(in_byte);
        end
      end
      default: begin
        if (in_byte == ced_pkg::CHAR_NUL) begin
          emit      = 1'b1;
          job.byte0 = ced_pkg::CHAR_NUL;
          job.last  = 1'b1;
        end else if (in_byte == ced_pkg::CHAR_BACKSLASH) begin
          mode_next = ced_pkg::MODE_ESCAPE;
        end else begin
          emit      = 1'b1;
          job.byte0 = in_byte;
        end
      end
    endcase
  end

endmodule

@@ hdl/ced_queue.sv @@
// ----------------------------------------------------------------------------
// ced_queue
// Small job queue between parser and output stage.
// ----------------------------------------------------------------------------
module ced_queue #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ced_pkg::job_t push_job,
  output logic          not_full,
  output logic          not_empty,
  input  logic          pop,
  output ced_pkg::job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ced_pkg::job_t   mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign not_full  = (count != CntFull);
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ced_back.sv @@
// ----------------------------------------------------------------------------
// ced_back
// Output stage: holds one job in a register and sends its characters one
// transaction at a time.
// ----------------------------------------------------------------------------
module ced_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ced_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  ced_pkg::job_t cur;
  logic          have;
  logic          second;
  logic          final_char;
  logic          out_fire;

  assign final_char = !cur.two || second;
  assign out_fire   = have && out_ready;
  assign q_pop      = q_valid && (!have || (out_fire && final_char));

  assign out_valid = have;
  assign out_byte  = second ? cur.byte1 : cur.byte0;
  assign out_last  = final_char && cur.last;

  // Control: load a new job or step to its second character
  always_ff @(posedge clk) begin
    if (rst) begin
      have   <= 1'b0;
      second <= 1'b0;
    end else if (q_pop) begin
      have   <= 1'b1;
      second <= 1'b0;
    end else if (out_fire) begin
      if (final_char) begin
        have   <= 1'b0;
        second <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

endmodule

@@ hdl/ced_checker.sv @@
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks for the C escape sequence decoder.
// ----------------------------------------------------------------------------
module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // Drop output valid after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Open input after reset with an empty queue
  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // Terminator is always a zero character
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == 8'h00)
    else $error("last set on a nonzero character");

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);
